### hw/rtl/abd_pkg.sv
// Shared types, constants and coefficient tables of the ADPCM block decoder.
package abd_pkg;

   // Byte positions inside a sixteen-byte block.
   localparam logic [3:0] POS_HEADER = 4'd0;
   localparam logic [3:0] POS_FLAGS  = 4'd1;
   localparam logic [3:0] POS_DATA   = 4'd2;

   // Highest filter number that has coefficients.
   localparam logic [3:0] FILTER_MAX = 4'd4;

   // The serial multiplier takes two coefficient bits per cycle.
   localparam int unsigned DIGIT_STEPS = 4;

   localparam logic signed [19:0] SAMPLE_MAX = 20'sd32767;
   localparam logic signed [19:0] SAMPLE_MIN = -20'sd32768;

   typedef struct packed {
      logic       key_on;
      logic [7:0] block_byte;
   } req_payload_type;

   typedef struct packed {
      logic signed [15:0] sample;
      logic [4:0]         sample_index;
      logic               last_of_pair;
      logic               loop_end;
      logic               loop_repeat;
      logic               loop_start;
   } rsp_payload_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_LOAD_A,
      ST_MUL_A,
      ST_MUL_B,
      ST_FINISH,
      ST_EMIT
   } abd_state_type;

   // Weight of the newer history sample for each filter.
   function automatic logic signed [7:0] coef_newer(input logic [2:0] filter);
      logic signed [7:0] k;
      unique case (filter)
         3'd1:    k = 8'sd60;
         3'd2:    k = 8'sd115;
         3'd3:    k = 8'sd98;
         3'd4:    k = 8'sd122;
         default: k = 8'sd0;
      endcase
      return k;
   endfunction

   // Weight of the older history sample for each filter.
   function automatic logic signed [7:0] coef_older(input logic [2:0] filter);
      logic signed [7:0] k;
      unique case (filter)
         3'd2:    k = -8'sd52;
         3'd3:    k = -8'sd55;
         3'd4:    k = -8'sd60;
         default: k = 8'sd0;
      endcase
      return k;
   endfunction

endpackage

### hw/rtl/adpcm_block_decoder.sv
// Top level of the ADPCM block decoder with its digit-serial filter multiplier.
//
// The decoder takes a sixteen-byte sound block one byte per input transaction: a header
// byte (shift in the low nibble, filter in the high nibble), a flags byte, and fourteen
// data bytes that each yield two 16-bit samples, low nibble first. Header and flags
// bytes are absorbed without leaving the idle state and give no result. A data byte
// is first accepted, and then for each of its two samples the decoder takes a setup
// step, a pass multiplying the newer history sample and a pass multiplying the older
// one (a shift-and-add multiplier that consumes two coefficient bits per cycle), a
// step to add and saturate, and a step to hand the sample to the output register.
// That shared serial multiplier sets the throughput.
// The output register lets the next byte be accepted while the second sample of the
// previous byte still waits to be taken. Setting key_on with a byte clears the sample
// history, the loop flags and the byte position before that byte is used, so the byte
// is taken as a header. Filter numbers above four behave as filter zero, and every
// sample saturates to the 16-bit range before it is output and kept as history.
module adpcm_block_decoder
   import abd_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_stall,
   input  req_payload_type req_data,
   output logic            rsp_valid,
   input  logic            rsp_stall,
   output rsp_payload_type rsp_data
);

   abd_state_type state_ff, state_in;

   // Block state.
   logic [3:0]         pos_ff;
   logic [3:0]         shift_ff;
   logic [2:0]         filter_ff;
   logic [2:0]         flags_ff;
   logic signed [15:0] hist_new_ff;
   logic signed [15:0] hist_old_ff;

   // Per-byte working registers.
   logic [7:0]         byte_ff;
   logic               nib_hi_ff;
   logic [4:0]         idx_ff;

   // Serial multiplier: the multiplicand shifts left and the coefficient shifts right
   // by one digit per cycle while the accumulator collects the partial products.
   logic signed [23:0] mcand_ff;
   logic [6:0]         mplier_ff;
   logic signed [23:0] acc_ff;
   logic [1:0]         cnt_ff;
   logic signed [18:0] sum_ff;

   logic               rsp_valid_ff;
   rsp_payload_type    rsp_data_ff;

   // Handshake and control.
   logic       accept;
   logic       out_free;
   logic       emit_load;
   logic       mul_last;
   logic [3:0] pos_eff;
   logic       is_data;

   assign pos_eff  = req_data.key_on ? POS_HEADER : pos_ff;
   assign is_data  = (pos_eff >= POS_DATA);
   assign mul_last = (cnt_ff == 2'(DIGIT_STEPS - 1));

   always_comb begin
      req_stall = (state_ff != ST_IDLE);
      accept    = (state_ff == ST_IDLE) && req_valid;
      out_free  = !rsp_valid_ff || !rsp_stall;
      emit_load = (state_ff == ST_EMIT) && out_free;
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid && is_data) begin
               state_in = ST_LOAD_A;
            end
         end
         ST_LOAD_A: state_in = ST_MUL_A;
         ST_MUL_A: begin
            if (mul_last) begin
               state_in = ST_MUL_B;
            end
         end
         ST_MUL_B: begin
            if (mul_last) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: state_in = ST_EMIT;
         ST_EMIT: begin
            if (out_free) begin
               state_in = nib_hi_ff ? ST_IDLE : ST_LOAD_A;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Datapath terms.
   logic signed [7:0]  k_new;
   logic signed [7:0]  k_old;
   logic [3:0]         nibble;
   logic signed [15:0] nib_term;
   logic signed [23:0] partial;
   logic signed [23:0] acc_in;
   logic signed [18:0] sum_in;
   logic signed [19:0] total;
   logic signed [15:0] sample_sat;
   logic [3:0]         hdr_filter;

   assign k_new      = coef_newer(filter_ff);
   assign k_old      = coef_older(filter_ff);
   assign nibble     = nib_hi_ff ? byte_ff[7:4] : byte_ff[3:0];
   assign nib_term   = $signed({nibble, 12'd0}) >>> shift_ff;
   assign hdr_filter = req_data.block_byte[7:4];

   // One digit of the coefficient times the multiplicand.
   always_comb begin
      partial = '0;
      if (mplier_ff[0]) begin
         partial = mcand_ff;
      end
      if (mplier_ff[1]) begin
         partial = partial + (mcand_ff <<< 1);
      end
      acc_in = acc_ff + partial;
   end

   // The first product, scaled down, joins the nibble term at the end of its pass.
   assign sum_in = {{3{nib_term[15]}}, nib_term} + {acc_in[23], acc_in[23:6]};
   assign total  = {sum_ff[18], sum_ff} + {{2{acc_ff[23]}}, acc_ff[23:6]};

   always_comb begin
      priority if (total > SAMPLE_MAX) begin
         sample_sat = 16'sh7fff;
      end else if (total < SAMPLE_MIN) begin
         sample_sat = -16'sh8000;
      end else begin
         sample_sat = total[15:0];
      end
   end

   // Multiplicand setup: a negative coefficient negates the history sample instead.
   function automatic logic signed [23:0] mcand_of(input logic signed [15:0] h,
                                                  input logic signed [7:0]  k);
      logic signed [23:0] ext;
      ext = {{8{h[15]}}, h};
      return k[7] ? -ext : ext;
   endfunction

   function automatic logic [6:0] mag_of(input logic signed [7:0] k);
      logic signed [7:0] m;
      m = k[7] ? -k : k;
      return m[6:0];
   endfunction

   // Control and block state.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         pos_ff       <= POS_HEADER;
         shift_ff     <= '0;
         filter_ff    <= '0;
         flags_ff     <= '0;
         hist_new_ff  <= '0;
         hist_old_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (accept) begin
            pos_ff <= pos_eff + 4'd1;
            if (req_data.key_on) begin
               flags_ff    <= '0;
               hist_new_ff <= '0;
               hist_old_ff <= '0;
            end
            priority if (pos_eff == POS_HEADER) begin
               shift_ff  <= req_data.block_byte[3:0];
               filter_ff <= (hdr_filter <= FILTER_MAX) ? hdr_filter[2:0] : 3'd0;
            end else if (pos_eff == POS_FLAGS) begin
               flags_ff <= req_data.block_byte[2:0];
            end else begin
            end
         end
         if (state_ff == ST_FINISH) begin
            hist_old_ff <= hist_new_ff;
            hist_new_ff <= sample_sat;
         end
         if (emit_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Working registers and the serial multiplier.
   always_ff @(posedge clock) begin
      if (accept) begin
         byte_ff   <= req_data.block_byte;
         nib_hi_ff <= 1'b0;
         idx_ff    <= {pos_eff - POS_DATA, 1'b0};
      end
      unique case (state_ff)
         ST_LOAD_A: begin
            mcand_ff  <= mcand_of(hist_new_ff, k_new);
            mplier_ff <= mag_of(k_new);
            acc_ff    <= '0;
            cnt_ff    <= '0;
         end
         ST_MUL_A: begin
            cnt_ff <= cnt_ff + 2'd1;
            if (mul_last) begin
               sum_ff    <= sum_in;
               mcand_ff  <= mcand_of(hist_old_ff, k_old);
               mplier_ff <= mag_of(k_old);
               acc_ff    <= '0;
            end else begin
               acc_ff    <= acc_in;
               mcand_ff  <= mcand_ff <<< 2;
               mplier_ff <= mplier_ff >> 2;
            end
         end
         ST_MUL_B: begin
            cnt_ff    <= cnt_ff + 2'd1;
            acc_ff    <= acc_in;
            mcand_ff  <= mcand_ff <<< 2;
            mplier_ff <= mplier_ff >> 2;
         end
         ST_EMIT: begin
            if (out_free && !nib_hi_ff) begin
               nib_hi_ff <= 1'b1;
               idx_ff    <= idx_ff + 5'd1;
            end
         end
         default: begin
         end
      endcase
      if (emit_load) begin
         rsp_data_ff.sample       <= hist_new_ff;
         rsp_data_ff.sample_index <= idx_ff;
         rsp_data_ff.last_of_pair <= nib_hi_ff;
         rsp_data_ff.loop_end     <= flags_ff[0];
         rsp_data_ff.loop_repeat  <= flags_ff[1];
         rsp_data_ff.loop_start   <= flags_ff[2];
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

### bench/tb.sv
// Self-checking testbench for the ADPCM block decoder, with a built-in sample predictor.
module tb
   import abd_pkg::*;
();

   timeunit 1ns;
   timeprecision 1ps;

   // Number of random input transactions that follow the directed table.
   localparam int RANDOM_ITEMS = 750;
   // Cycles in a row without any accepted transaction before the run is declared hung.
   // The longest legal quiet stretch is the long receiver hold-off below, plus the time
   // for one data byte to be decoded.
   localparam int WATCHDOG_LIMIT = 4000;
   // Length of the long receiver hold-off that makes the decoder fill up.
   localparam int HOLD_CYCLES = 300;
   // Cycles to keep watching the result side after the last expected sample.
   localparam int DRAIN_CYCLES = 60;
   localparam int DIRECTED_ROWS = 25;

   logic            clock = 1'b0;
   logic            reset = 1'b1;
   logic            req_valid = 1'b0;
   logic            req_stall;
   req_payload_type req_data = '0;
   logic            rsp_valid;
   logic            rsp_stall = 1'b0;
   rsp_payload_type rsp_data;

   adpcm_block_decoder u_top (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   // One row of the directed table. When typed is set, the two samples that the data
   // byte yields are written in by hand and take the place of the predicted ones.
   typedef struct packed {
      logic               key_on;
      logic [7:0]         block_byte;
      logic               typed;
      logic signed [15:0] low_sample;
      logic signed [15:0] high_sample;
   } directed_row_type;

   // The directed table walks through the special cases of the decoder. The first
   // block uses filter zero and shift zero, so each sample is just its nibble placed
   // in the top four bits. Later rows cover a filter number above four, a header
   // arriving by key-on in the middle of a block, shifts of 13 and 15, a flags byte
   // with its upper bits set, and a filter-four block that overflows and saturates.
   directed_row_type directed_rows [DIRECTED_ROWS] = '{
      '{1'b1, 8'h00, 1'b0, 16'sd0,      16'sd0},
      '{1'b0, 8'h07, 1'b0, 16'sd0,      16'sd0},
      '{1'b0, 8'h00, 1'b1, 16'sd0,      16'sd0},
      '{1'b0, 8'h77, 1'b1, 16'sd28672,  16'sd28672},
      '{1'b0, 8'h88, 1'b1, -16'sd32768, -16'sd32768},
      '{1'b0, 8'hF1, 1'b1, 16'sd4096,   -16'sd4096},
      '{1'b1, 8'hC4, 1'b0, 16'sd0,      16'sd0},
      '{1'b0, 8'hFF, 1'b0, 16'sd0,      16'sd0},
      '{1'b0, 8'h87, 1'b1, 16'sd1792,   -16'sd2048},
      '{1'b1, 8'h4D, 1'b0, 16'sd0,      16'sd0},
      '{1'b0, 8'h00, 1'b0, 16'sd0,      16'sd0},
      '{1'b0, 8'h7F, 1'b0, 16'sd0,      16'sd0},
      '{1'b0, 8'h80, 1'b0, 16'sd0,      16'sd0},
      '{1'b1, 8'hFF, 1'b0, 16'sd0,      16'sd0},
      '{1'b0, 8'h02, 1'b0, 16'sd0,      16'sd0},
      '{1'b0, 8'h8F, 1'b1, -16'sd1,     -16'sd1},
      '{1'b0, 8'h70, 1'b1, 16'sd0,      16'sd0},
      '{1'b1, 8'h40, 1'b0, 16'sd0,      16'sd0},
      '{1'b0, 8'h01, 1'b0, 16'sd0,      16'sd0},
      '{1'b0, 8'h77, 1'b1, 16'sd28672,  16'sd32767},
      '{1'b0, 8'h88, 1'b0, 16'sd0,      16'sd0},
      '{1'b0, 8'h88, 1'b0, 16'sd0,      16'sd0},
      '{1'b1, 8'h31, 1'b0, 16'sd0,      16'sd0},
      '{1'b0, 8'h04, 1'b0, 16'sd0,      16'sd0},
      '{1'b0, 8'hE9, 1'b0, 16'sd0,      16'sd0}
   };

   // Filter weights for the newer and the older history sample, indexed by filter.
   int newer_weight [5] = '{0, 60, 115, 98, 122};
   int older_weight [5] = '{0, 0, -52, -55, -60};

   // Predictor state: a private copy of what the decoder keeps between bytes.
   logic [3:0]         next_position = POS_HEADER;
   logic [3:0]         shift_q = 4'd0;
   logic [2:0]         filter_q = 3'd0;
   logic [2:0]         flags_q = 3'd0;
   logic signed [15:0] history_newer = 16'sd0;
   logic signed [15:0] history_older = 16'sd0;

   // Samples that the decoder still owes, oldest first.
   rsp_payload_type expected_samples [$];

   // Idling controls shared by the sender and the receiver processes.
   int send_idle_pct = 0;
   int recv_stall_pct = 0;
   bit hold_request = 1'b0;

   int error_count = 0;
   int items_sent = 0;

   // The clock runs from time zero with a 10 ns period.
   initial begin
      forever #5 clock = ~clock;
   end

   // Decodes one nibble with the current shift and filter and advances the history.
   // The nibble sits in the top four bits of a 16-bit word, is shifted right
   // arithmetically, and each filtered history term is rounded toward minus infinity
   // on its own before the sum is saturated to 16 bits.
   function automatic logic signed [15:0] filter_nibble(input logic [3:0] nibble);
      int term;
      int sum;
      logic signed [15:0] word;
      word = {nibble, 12'h000};
      term = int'(word) >>> shift_q;
      sum = term + ((int'(history_newer) * newer_weight[filter_q]) >>> 6)
                 + ((int'(history_older) * older_weight[filter_q]) >>> 6);
      if (sum > 32767) sum = 32767;
      if (sum < -32768) sum = -32768;
      history_older = history_newer;
      history_newer = 16'(sum);
      return history_newer;
   endfunction

   // Applies one accepted byte to the predictor and queues the samples it yields.
   // Header and flags bytes only update the state; a data byte yields two samples,
   // low nibble first. With typed set, the hand-written samples are queued instead.
   task automatic decode_byte(input req_payload_type item, input logic typed,
                              input logic signed [15:0] low_sample,
                              input logic signed [15:0] high_sample);
      logic [3:0] position;
      logic signed [15:0] predicted;
      rsp_payload_type result;
      int half;
      if (item.key_on) begin
         next_position = POS_HEADER;
         flags_q = 3'd0;
         history_newer = 16'sd0;
         history_older = 16'sd0;
      end
      position = next_position;
      if (position == POS_HEADER) begin
         shift_q = item.block_byte[3:0];
         filter_q = (item.block_byte[7:4] <= FILTER_MAX) ? item.block_byte[6:4] : 3'd0;
      end else if (position == POS_FLAGS) begin
         flags_q = item.block_byte[2:0];
      end else begin
         for (half = 0; half < 2; half++) begin
            predicted = filter_nibble(half == 0 ? item.block_byte[3:0]
                                                : item.block_byte[7:4]);
            if (typed) predicted = (half == 0) ? low_sample : high_sample;
            result.sample = predicted;
            result.sample_index = 5'((position - POS_DATA) * 2 + half);
            result.last_of_pair = (half == 1);
            result.loop_end = flags_q[0];
            result.loop_repeat = flags_q[1];
            result.loop_start = flags_q[2];
            expected_samples.push_back(result);
         end
      end
      // The position is four bits wide, so byte 15 wraps back to the header.
      next_position = position + 4'd1;
   endtask

   // Offers one transaction on the input channel. Idle cycles are inserted before it
   // at the current sender rate; once valid is up, the payload is held until the
   // decoder takes it, and the predictor runs at the edge of acceptance.
   task automatic offer_byte(input logic key_on, input logic [7:0] block_byte,
                             input logic typed, input logic signed [15:0] low_sample,
                             input logic signed [15:0] high_sample);
      req_payload_type item;
      item.key_on = key_on;
      item.block_byte = block_byte;
      @(negedge clock);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data <= item;
      do @(posedge clock); while (req_stall);
      decode_byte(item, typed, low_sample, high_sample);
      items_sent++;
   endtask

   task automatic report_field(input string field, input int want, input int got);
      error_count++;
      $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
   endtask

   // Compares one accepted result transaction with the oldest expected sample.
   task automatic check_sample(input rsp_payload_type got);
      rsp_payload_type want;
      if (expected_samples.size() == 0) begin
         error_count++;
         $display("%0t ns: unexpected result transaction, expected none, actual %0d at %0d",
                  $time, got.sample, got.sample_index);
         return;
      end
      want = expected_samples.pop_front();
      if (got.sample !== want.sample) report_field("sample", want.sample, got.sample);
      if (got.sample_index !== want.sample_index)
         report_field("sample_index", want.sample_index, got.sample_index);
      if (got.last_of_pair !== want.last_of_pair)
         report_field("last_of_pair", want.last_of_pair, got.last_of_pair);
      if (got.loop_end !== want.loop_end)
         report_field("loop_end", want.loop_end, got.loop_end);
      if (got.loop_repeat !== want.loop_repeat)
         report_field("loop_repeat", want.loop_repeat, got.loop_repeat);
      if (got.loop_start !== want.loop_start)
         report_field("loop_start", want.loop_start, got.loop_start);
   endtask

   // Result side. Outputs are sampled at the rising edge, and the stall for the next
   // cycle is chosen at the falling edge. A hold-off request keeps the stall high for
   // the length of the hold-off, counted here, while the sender keeps offering bytes.
   initial begin : result_side
      int hold_left;
      hold_left = 0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid && !rsp_stall) check_sample(rsp_data);
         @(negedge clock);
         if (hold_request) begin
            hold_request = 1'b0;
            hold_left = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= ($urandom_range(99) < recv_stall_pct);
         end
      end
   end

   // Watchdog: a hang shows up as a long stretch in which no transaction is accepted
   // on either channel.
   initial begin : watchdog
      int quiet_cycles;
      quiet_cycles = 0;
      forever begin
         @(posedge clock);
         if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall))
            quiet_cycles = 0;
         else
            quiet_cycles++;
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t ns: no transaction for %0d cycles", $time, quiet_cycles);
            $display("[FAIL] regression broken");
            $finish;
         end
      end
   end

   // Stimulus: reset, the directed table, then random blocks in four idling phases.
   initial begin : stimulus
      int row;
      int length;
      int random_done;
      bit aligned;
      logic key_on;
      logic [7:0] header;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      for (row = 0; row < DIRECTED_ROWS; row++)
         offer_byte(directed_rows[row].key_on, directed_rows[row].block_byte,
                    directed_rows[row].typed, directed_rows[row].low_sample,
                    directed_rows[row].high_sample);

      // The directed table ends in the middle of a block, so the first random block
      // has to realign with a key-on. The long hold-off starts with the random part,
      // while the sender offers back to back.
      aligned = 1'b0;
      hold_request = 1'b1;
      while (items_sent - DIRECTED_ROWS < RANDOM_ITEMS) begin
         random_done = items_sent - DIRECTED_ROWS;
         if (random_done < RANDOM_ITEMS / 4) begin
            send_idle_pct = 0;
            recv_stall_pct = 0;
         end else if (random_done < RANDOM_ITEMS / 2) begin
            send_idle_pct = 74;
            recv_stall_pct = 0;
         end else if (random_done < 3 * RANDOM_ITEMS / 4) begin
            send_idle_pct = 0;
            recv_stall_pct = 74;
         end else begin
            send_idle_pct = 24;
            recv_stall_pct = 24;
         end

         if ($urandom_range(99) < 85) begin
            // A well-formed block with random content. Most headers carry a filter
            // that has coefficients; the rest carry any filter nibble at all.
            key_on = !aligned || ($urandom_range(99) < 15);
            if ($urandom_range(99) < 85)
               header = {1'b0, 3'($urandom_range(4)), 4'($urandom)};
            else
               header = 8'($urandom);
            offer_byte(key_on, header, 1'b0, 16'sd0, 16'sd0);
            repeat (15) offer_byte(1'b0, 8'($urandom), 1'b0, 16'sd0, 16'sd0);
            aligned = 1'b1;
         end else begin
            // A broken stretch: random bytes with key-on dropped in at random.
            length = $urandom_range(1, 20);
            repeat (length)
               offer_byte($urandom_range(99) < 20, 8'($urandom), 1'b0, 16'sd0, 16'sd0);
            aligned = 1'b0;
         end
      end

      @(negedge clock);
      req_valid <= 1'b0;
      send_idle_pct = 0;
      recv_stall_pct = 0;

      // Wait for every owed sample, then watch a little longer for stray results.
      while (expected_samples.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (error_count == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end

endmodule
